/* sv/lbd_pkg.sv */
`default_nettype none

package lbd_pkg;

    localparam int NUM_LEDS_DEF   = 3;
    localparam int MAX_LEVEL_DEF  = 15;
    localparam int NUM_LEVEL_REGS = 3;
    localparam int SCAN_RATE_HZ   = 800;

    localparam int BLINK_W    = 16;
    localparam int LEVEL_W    = 4;
    localparam int DIM_W      = 4;
    localparam int IDX_W      = 2;
    localparam int MAXL_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [BLINK_W-1:0] BLINK_HALF_RESET = BLINK_W'(SCAN_RATE_HZ / 3 / 2);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_BLINK = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL0     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL1     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL2     = CFG_IDX_W'(3);

    typedef struct packed {
        logic [BLINK_W-1:0]                     blink_half_period;
        logic [NUM_LEVEL_REGS-1:0][LEVEL_W-1:0] level;
    } cfg_t;

    typedef struct packed {
        op_t              operation;
        logic [IDX_W-1:0] led_index;
        logic             value;
    } item_t;

    typedef struct packed {
        logic             pin_update;
        logic [IDX_W-1:0] pin_index;
        logic             pin_level;
        logic             blinking_status;
    } result_t;

endpackage

`default_nettype wire

/* sv/led_blink_dim_scanner.sv */
// LED scan, blink and dim controller.
// Input channel (s_valid/s_ready): one command word per handshake with
// s_operation (tick, write on/off, set blinking, clear all), s_led_index
// and s_value. Every word returns exactly one result word on the m_
// channel: pin drive on a tick, and the blink enable of the addressed LED.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): register 0 is
// the blink half period, registers 1 to 3 the LED levels; cfg_ready is
// always high, and writes belong in idle periods.
// A result word passes from the input handshake into the input register,
// then through the per-LED update into the result register when that
// register is empty or being read. Throughput is one word per cycle while
// the receiver takes results; all LED state updates from the input
// register as the word moves on, so back-to-back words then never wait.
// When the receiver stalls, the result register holds and the input
// register fills; s_ready drops only when both are full.
// Reset (aresetn, synchronous, active low) empties both registers, clears
// all LED state and counters, and loads the register defaults.
`default_nettype none

module led_blink_dim_scanner #(
    parameter int NUM_LEDS  = lbd_pkg::NUM_LEDS_DEF,
    parameter int MAX_LEVEL = lbd_pkg::MAX_LEVEL_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_operation,
    input  wire logic [lbd_pkg::IDX_W-1:0]       s_led_index,
    input  wire logic                            s_value,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_pin_update,
    output logic [lbd_pkg::IDX_W-1:0]            m_pin_index,
    output logic                                 m_pin_level,
    output logic                                 m_blinking_status,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lbd_pkg::cfg_t    cfg;
    lbd_pkg::item_t   item_reg;
    lbd_pkg::result_t result;
    lbd_pkg::result_t res_reg;

    logic in_valid_reg;
    logic in_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;
    logic s_fire;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_fire    = s_valid && s_ready;

    lbd_cfg_regs #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lbd_led_core #(
        .NUM_LEDS  (NUM_LEDS),
        .MAX_LEVEL (MAX_LEVEL)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (advance),
        .item      (item_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.operation <= lbd_pkg::op_t'(s_operation);
            item_reg.led_index <= s_led_index;
            item_reg.value     <= s_value;
        end
        if (advance) begin
            res_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_pin_update      = res_reg.pin_update;
    assign m_pin_index       = res_reg.pin_index;
    assign m_pin_level       = res_reg.pin_level;
    assign m_blinking_status = res_reg.blinking_status;

    a_empty_input_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    a_item_moves : assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("pending word did not reach the result register");

    a_idle_pins : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pin_update |-> (m_pin_index == '0) && !m_pin_level)
        else $error("pin fields driven on a non-tick result");

endmodule

`default_nettype wire

/* sv/lbd_cfg_regs.sv */
`default_nettype none

module lbd_cfg_regs #(
    parameter int MAX_LEVEL = lbd_pkg::MAX_LEVEL_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [lbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lbd_pkg::cfg_t                         cfg
);

    localparam logic [lbd_pkg::MAXL_W-1:0]  MAX_LEVEL_W = MAX_LEVEL[lbd_pkg::MAXL_W-1:0];
    localparam logic [lbd_pkg::LEVEL_W-1:0] LEVEL_RESET = MAX_LEVEL_W[lbd_pkg::LEVEL_W-1:0];

    lbd_pkg::cfg_t cfg_reg;
    lbd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                lbd_pkg::REG_BLINK_HALF: begin
                    cfg_next.blink_half_period = cfg_data[lbd_pkg::BLINK_W-1:0];
                end
                lbd_pkg::REG_LEVEL0: begin
                    cfg_next.level[0] = cfg_data[lbd_pkg::LEVEL_W-1:0];
                end
                lbd_pkg::REG_LEVEL1: begin
                    cfg_next.level[1] = cfg_data[lbd_pkg::LEVEL_W-1:0];
                end
                lbd_pkg::REG_LEVEL2: begin
                    cfg_next.level[2] = cfg_data[lbd_pkg::LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_half_period <= lbd_pkg::BLINK_HALF_RESET;
            cfg_reg.level             <= {lbd_pkg::NUM_LEVEL_REGS{LEVEL_RESET}};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/lbd_led_core.sv */
`default_nettype none

module lbd_led_core #(
    parameter int NUM_LEDS  = lbd_pkg::NUM_LEDS_DEF,
    parameter int MAX_LEVEL = lbd_pkg::MAX_LEVEL_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       item_fire,
    input  lbd_pkg::item_t  item,
    input  lbd_pkg::cfg_t   cfg,
    output lbd_pkg::result_t result
);

    localparam int SCAN_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [SCAN_W-1:0] LAST_POS = SCAN_W'(NUM_LEDS - 1);
    localparam logic [lbd_pkg::MAXL_W-1:0] MAX_LEVEL_W = MAX_LEVEL[lbd_pkg::MAXL_W-1:0];

    logic [SCAN_W-1:0] scan_pos_reg;
    logic [SCAN_W-1:0] scan_pos_next;
    logic [SCAN_W+1:0] scan_pos_ext;

    logic is_tick;
    logic is_write;
    logic is_blink;
    logic is_clear;

    logic [NUM_LEDS-1:0] lit_vec;
    logic [NUM_LEDS-1:0] enable_next_vec;
    logic                lit_sel;
    logic                status;

    assign is_tick  = (item.operation == lbd_pkg::OP_TICK);
    assign is_write = (item.operation == lbd_pkg::OP_WRITE);
    assign is_blink = (item.operation == lbd_pkg::OP_BLINK);
    assign is_clear = (item.operation == lbd_pkg::OP_CLEAR);

    for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
        logic                          led_on_reg;
        logic                          led_on_next;
        logic                          enable_reg;
        logic                          enable_next;
        logic                          phase_reg;
        logic                          phase_next;
        logic [lbd_pkg::BLINK_W-1:0]   bcnt_reg;
        logic [lbd_pkg::BLINK_W-1:0]   bcnt_next;
        logic [lbd_pkg::DIM_W-1:0]     dcnt_reg;
        logic [lbd_pkg::DIM_W-1:0]     dcnt_next;
        logic [lbd_pkg::MAXL_W-1:0]    level_w;
        logic                          sel_scan;
        logic                          sel_addr;
        logic                          blink_wrap;
        logic                          phase_tick;
        logic                          pass_blink;
        logic                          dim_active;
        logic                          dim_hit;

        if (i < lbd_pkg::NUM_LEVEL_REGS) begin : g_level
            assign level_w = {{(lbd_pkg::MAXL_W - lbd_pkg::LEVEL_W){1'b0}}, cfg.level[i]};
        end else begin : g_full
            assign level_w = MAX_LEVEL_W;
        end

        assign sel_scan   = is_tick && (int'(scan_pos_reg) == i);
        assign sel_addr   = (int'(item.led_index) == i);
        assign blink_wrap = (bcnt_reg >= cfg.blink_half_period);
        assign phase_tick = blink_wrap ? !phase_reg : phase_reg;
        assign pass_blink = !enable_reg || !phase_tick;
        assign dim_active = pass_blink && (level_w < MAX_LEVEL_W);
        assign dim_hit    = dim_active && (dcnt_reg == level_w[lbd_pkg::DIM_W-1:0]);

        always_comb begin
            led_on_next = led_on_reg;
            enable_next = enable_reg;
            phase_next  = phase_reg;
            bcnt_next   = bcnt_reg;
            dcnt_next   = dcnt_reg;
            if (sel_scan) begin
                if (enable_reg) begin
                    bcnt_next  = blink_wrap ? '0 : bcnt_reg + 1'b1;
                    phase_next = phase_tick;
                end
                if (dim_active) begin
                    dcnt_next = dim_hit ? '0 : dcnt_reg + 1'b1;
                end
            end
            if (is_write && sel_addr) begin
                led_on_next = item.value;
            end
            if (is_blink && sel_addr) begin
                enable_next = item.value;
                phase_next  = 1'b0;
            end
            if (is_clear) begin
                led_on_next = 1'b0;
                enable_next = 1'b0;
                phase_next  = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                led_on_reg <= 1'b0;
                enable_reg <= 1'b0;
                phase_reg  <= 1'b0;
                bcnt_reg   <= '0;
                dcnt_reg   <= '0;
            end else if (item_fire) begin
                led_on_reg <= led_on_next;
                enable_reg <= enable_next;
                phase_reg  <= phase_next;
                bcnt_reg   <= bcnt_next;
                dcnt_reg   <= dcnt_next;
            end
        end

        assign lit_vec[i]         = pass_blink && !dim_hit && led_on_reg;
        assign enable_next_vec[i] = enable_next;
    end

    always_comb begin
        lit_sel = 1'b0;
        status  = 1'b0;
        for (int i = 0; i < NUM_LEDS; i++) begin
            if (int'(scan_pos_reg) == i) begin
                lit_sel = lit_vec[i];
            end
            if (int'(item.led_index) == i) begin
                status = enable_next_vec[i];
            end
        end
    end

    always_comb begin
        scan_pos_next = scan_pos_reg;
        if (is_tick) begin
            scan_pos_next = (scan_pos_reg == LAST_POS) ? '0 : scan_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_pos_reg <= '0;
        end else if (item_fire) begin
            scan_pos_reg <= scan_pos_next;
        end
    end

    assign scan_pos_ext = {2'b00, scan_pos_reg};

    always_comb begin
        result.pin_update      = is_tick;
        result.pin_index       = is_tick ? scan_pos_ext[lbd_pkg::IDX_W-1:0] : '0;
        result.pin_level       = is_tick && lit_sel;
        result.blinking_status = status;
    end

endmodule

`default_nettype wire

/* tb/tb_led_blink_dim_scanner.sv */
`default_nettype none

class pin_drive_tracker;

    logic [lbd_pkg::BLINK_W-1:0] half_period;
    logic [lbd_pkg::LEVEL_W-1:0] level [lbd_pkg::NUM_LEVEL_REGS];

    logic [lbd_pkg::IDX_W-1:0]   scan_pos;
    logic                        led_on    [lbd_pkg::NUM_LEDS_DEF];
    logic                        blink_en  [lbd_pkg::NUM_LEDS_DEF];
    logic                        blink_ph  [lbd_pkg::NUM_LEDS_DEF];
    logic [lbd_pkg::BLINK_W-1:0] blink_cnt [lbd_pkg::NUM_LEDS_DEF];
    logic [lbd_pkg::DIM_W-1:0]   dim_cnt   [lbd_pkg::NUM_LEDS_DEF];

    lbd_pkg::result_t            pending_drive [$];
    int                          mismatch_cnt;

    function new();
        half_period = lbd_pkg::BLINK_HALF_RESET;
        for (int i = 0; i < lbd_pkg::NUM_LEVEL_REGS; i++) begin
            level[i] = lbd_pkg::LEVEL_W'(lbd_pkg::MAX_LEVEL_DEF);
        end
        scan_pos = '0;
        for (int i = 0; i < lbd_pkg::NUM_LEDS_DEF; i++) begin
            led_on[i]    = 1'b0;
            blink_en[i]  = 1'b0;
            blink_ph[i]  = 1'b0;
            blink_cnt[i] = '0;
            dim_cnt[i]   = '0;
        end
        mismatch_cnt = 0;
    endfunction

    function void set_reg(logic [lbd_pkg::CFG_IDX_W-1:0] idx,
                          logic [lbd_pkg::CFG_DATA_W-1:0] data);
        if (idx == lbd_pkg::REG_BLINK_HALF) begin
            half_period = data[lbd_pkg::BLINK_W-1:0];
        end else if (idx == lbd_pkg::REG_LEVEL0) begin
            level[0] = data[lbd_pkg::LEVEL_W-1:0];
        end else if (idx == lbd_pkg::REG_LEVEL1) begin
            level[1] = data[lbd_pkg::LEVEL_W-1:0];
        end else if (idx == lbd_pkg::REG_LEVEL2) begin
            level[2] = data[lbd_pkg::LEVEL_W-1:0];
        end
    endfunction

    function void note_word(lbd_pkg::op_t op, logic [lbd_pkg::IDX_W-1:0] idx, logic val);
        lbd_pkg::result_t r;
        int               p;
        logic             lit;
        r = '0;
        case (op)
            lbd_pkg::OP_TICK: begin
                p = int'(scan_pos);
                if (p >= lbd_pkg::NUM_LEDS_DEF) p = 0;
                lit = 1'b1;
                if (blink_en[p]) begin
                    if (blink_cnt[p] < half_period) begin
                        blink_cnt[p] = blink_cnt[p] + 1'b1;
                    end else begin
                        blink_cnt[p] = '0;
                        blink_ph[p]  = ~blink_ph[p];
                    end
                    lit = ~blink_ph[p];
                end
                if (lit && int'(level[p]) < lbd_pkg::MAX_LEVEL_DEF) begin
                    if (dim_cnt[p] == level[p]) begin
                        lit        = 1'b0;
                        dim_cnt[p] = '0;
                    end else begin
                        dim_cnt[p] = dim_cnt[p] + 1'b1;
                    end
                end
                r.pin_update = 1'b1;
                r.pin_index  = lbd_pkg::IDX_W'(p);
                r.pin_level  = lit & led_on[p];
                scan_pos = (p + 1 >= lbd_pkg::NUM_LEDS_DEF) ? '0 : lbd_pkg::IDX_W'(p + 1);
            end
            lbd_pkg::OP_WRITE: begin
                if (idx < lbd_pkg::NUM_LEDS_DEF) led_on[idx] = val;
            end
            lbd_pkg::OP_BLINK: begin
                if (idx < lbd_pkg::NUM_LEDS_DEF) begin
                    blink_en[idx] = val;
                    blink_ph[idx] = 1'b0;
                end
            end
            default: begin
                for (int i = 0; i < lbd_pkg::NUM_LEDS_DEF; i++) begin
                    led_on[i]   = 1'b0;
                    blink_en[i] = 1'b0;
                    blink_ph[i] = 1'b0;
                end
            end
        endcase
        r.blinking_status = (idx < lbd_pkg::NUM_LEDS_DEF) ? blink_en[idx] : 1'b0;
        pending_drive.push_back(r);
    endfunction

    function void note_mismatch(string what, lbd_pkg::result_t want, lbd_pkg::result_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%s: expected upd=%0d idx=%0d lvl=%0d blink=%0d, got upd=%0d idx=%0d lvl=%0d blink=%0d",
                     what, want.pin_update, want.pin_index, want.pin_level,
                     want.blinking_status, got.pin_update, got.pin_index,
                     got.pin_level, got.blinking_status);
        end
    endfunction

    function void check_word(lbd_pkg::result_t got);
        lbd_pkg::result_t want;
        if (pending_drive.size() == 0) begin
            note_mismatch("unexpected word", '0, got);
        end else begin
            want = pending_drive.pop_front();
            if (got.pin_update !== want.pin_update || got.pin_index !== want.pin_index ||
                got.pin_level !== want.pin_level ||
                got.blinking_status !== want.blinking_status) begin
                note_mismatch("result word", want, got);
            end
        end
    endfunction

    function int pending();
        return pending_drive.size();
    endfunction

    function void close_out();
        if (pending_drive.size() != 0) begin
            mismatch_cnt++;
            $display("%0d result words never returned", pending_drive.size());
        end
    endfunction

endclass

module tb_led_blink_dim_scanner;

    import lbd_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;

    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_operation = '0;
    logic [IDX_W-1:0]      s_led_index = '0;
    logic                  s_value   = 1'b0;

    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_pin_update;
    logic [IDX_W-1:0]      m_pin_index;
    logic                  m_pin_level;
    logic                  m_blinking_status;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit                    hold_req  = 1'b0;

    pin_drive_tracker      sb = new();

    led_blink_dim_scanner i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_led_index       (s_led_index),
        .s_value           (s_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pin_update      (m_pin_update),
        .m_pin_index       (m_pin_index),
        .m_pin_level       (m_pin_level),
        .m_blinking_status (m_blinking_status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #4 aclk = ~aclk;

    task automatic send_word(op_t op, logic [IDX_W-1:0] idx, logic val);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_led_index <= idx;
        s_value     <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(op, idx, val);
    endtask

    task automatic send_random();
        int               pick;
        op_t              op;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            op = OP_TICK;
        end else if (pick < 74) begin
            op = OP_WRITE;
        end else if (pick < 96) begin
            op = OP_BLINK;
        end else begin
            op = OP_CLEAR;
        end
        idx = ($urandom_range(0, 9) == 0) ? IDX_W'(3) : IDX_W'($urandom_range(0, 2));
        send_word(op, idx, 1'($urandom));
    endtask

    task automatic idle(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic load_settings(logic [BLINK_W-1:0] half, logic [LEVEL_W-1:0] l0,
                                 logic [LEVEL_W-1:0] l1, logic [LEVEL_W-1:0] l2);
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        for (int r = 0; r < 5; r++) begin
            case (r)
                0: begin
                    reg_idx  = REG_BLINK_HALF;
                    reg_data = half;
                end
                1: begin
                    reg_idx  = REG_LEVEL0;
                    reg_data = {12'($urandom), l0};
                end
                2: begin
                    reg_idx  = REG_LEVEL1;
                    reg_data = {12'($urandom), l1};
                end
                3: begin
                    reg_idx  = REG_LEVEL2;
                    reg_data = {12'($urandom), l2};
                end
                default: begin
                    reg_idx  = CFG_IDX_W'($urandom_range(4, 255));
                    reg_data = CFG_DATA_W'($urandom);
                end
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx;
            cfg_data  <= reg_data;
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(reg_idx, reg_data);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count, bit squeeze);
        int burst;
        burst = $urandom_range(1, 30);
        for (int k = 0; k < count; k++) begin
            if (squeeze && k == count / 4) begin
                // stall the result side and keep offering words
                hold_req = 1'b1;
                repeat (24) send_random();
            end
            if (burst == 0) begin
                idle($urandom_range(0, 6));
                burst = $urandom_range(1, 30);
            end
            send_random();
            burst--;
        end
    endtask

    initial begin
        int mode;
        int span;
        int hold;
        int cyc;
        mode = 0;
        span = 0;
        hold = 0;
        cyc  = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = 64;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 150);
                end
                span--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((cyc % 5) < 3);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(result_t'({m_pin_update, m_pin_index, m_pin_level,
                                     m_blinking_status}));
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        load_settings(16'd1, 4'd0, 4'd3, 4'd15);
        send_word(OP_WRITE, 2'd0, 1'b1);
        send_word(OP_WRITE, 2'd1, 1'b1);
        send_word(OP_WRITE, 2'd2, 1'b1);
        send_word(OP_WRITE, 2'd3, 1'b1);
        repeat (3) send_word(OP_TICK, IDX_W'($urandom_range(0, 3)), 1'($urandom));
        send_word(OP_BLINK, 2'd0, 1'b1);
        send_word(OP_BLINK, 2'd3, 1'b1);
        repeat (6) send_word(OP_TICK, IDX_W'($urandom_range(0, 3)), 1'($urandom));
        send_word(OP_BLINK, 2'd0, 1'b0);
        send_word(OP_WRITE, 2'd1, 1'b0);
        repeat (3) send_word(OP_TICK, 2'd0, 1'b1);
        send_word(OP_CLEAR, 2'd2, 1'b1);
        repeat (3) send_word(OP_TICK, 2'd3, 1'b0);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: load_settings(16'd0, 4'd0, 4'd1, 4'd2);
                1: load_settings(16'hFFFF, 4'd15, 4'd15, 4'd15);
                2: load_settings(BLINK_HALF_RESET, 4'd14, 4'd15, 4'd7);
                3: load_settings(16'($urandom_range(1, 6)), 4'($urandom), 4'($urandom),
                                 4'($urandom));
                4: load_settings(16'($urandom_range(0, 40)), 4'($urandom), 4'($urandom),
                                 4'($urandom));
                default: load_settings(16'd2, 4'd15, 4'd0, 4'd15);
            endcase
            run_random(200, ph == 1 || ph == 4);
        end

        drain();
        repeat (10) @(posedge aclk);
        sb.close_out();
        if (sb.mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
